>>> design/fps_pkg.sv
// Shared types and constants for the funnel path smoother.
// Request, response and point types; no dependencies.
`default_nettype none
package fps_pkg;
   localparam int MAX_PORTALS   = 64;
   localparam int MAX_WAYPOINTS = 64;
   localparam int ITER_LIMIT    = (MAX_PORTALS + 1) * (MAX_WAYPOINTS + 2);

   localparam logic [6:0]  NO_PORTAL = 7'd64;
   localparam logic [16:0] NO_VERTEX = 17'h10000;

   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_CORNER = 2'd1;
   localparam logic [1:0] KIND_TARGET = 2'd2;

   localparam logic [2:0] CSR_START_X  = 3'd0;
   localparam logic [2:0] CSR_START_Y  = 3'd1;
   localparam logic [2:0] CSR_START_Z  = 3'd2;
   localparam logic [2:0] CSR_TARGET_X = 3'd3;
   localparam logic [2:0] CSR_TARGET_Y = 3'd4;
   localparam logic [2:0] CSR_TARGET_Z = 3'd5;
   localparam logic [2:0] CSR_MAX_WP   = 3'd6;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   typedef struct packed {
      logic               func;
      logic signed [31:0] left_x;
      logic signed [31:0] left_y;
      logic signed [31:0] left_z;
      logic signed [31:0] right_x;
      logic signed [31:0] right_y;
      logic signed [31:0] right_z;
      logic [15:0]        left_vertex;
      logic [15:0]        right_vertex;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [1:0]         kind;
      logic [6:0]         portal_index;
      logic [16:0]        vertex_index;
      logic               budget_exceeded;
      logic               last;
      logic               load_overflow;
   } rsp_type;
endpackage
`default_nettype wire

>>> design/funnel_path_smoother.sv
// Funnel path smoother: a load request (func 0) stores one portal (if MAX_PORTALS are
// already stored it stores nothing and sets load_overflow) and answers with one response
// on the cycle after acceptance. A run request (func 1) walks the stored portals with
// one shared 33x33 multiplier; each area test runs through S_AR1, S_AR2 and S_AR3, and
// each corner is read back (S_CREAD, S_CEMIT) before its restart walk. The waypoints are
// buffered and then stream out one per cycle; busy drops in the same cycle that the last
// one is presented. Responses cannot be stalled by the receiver. Depends on fps_pkg.
`default_nettype none
module funnel_path_smoother (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire fps_pkg::req_type req,
   output logic                 rsp_valid,
   output fps_pkg::rsp_type     rsp,
   input  wire logic            csr_we,
   input  wire logic [2:0]      csr_index,
   input  wire logic [31:0]     csr_wdata
);
   import fps_pkg::*;

   localparam int PA_W = $clog2(MAX_PORTALS);
   localparam int WA_W = $clog2(MAX_WAYPOINTS);
   localparam int GD_W = $clog2(ITER_LIMIT + 1);
   localparam logic signed [66:0] EPS = 67'sd42949;

   typedef struct packed {
      point_type  l;
      point_type  r;
      logic [15:0] lv;
      logic [15:0] rv;
   } portal_type;

   typedef struct packed {
      point_type   p;
      logic [1:0]  kind;
      logic [6:0]  portal;
      logic [16:0] vertex;
   } wp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_STEP, S_LOAD, S_AR1, S_AR2, S_AR3, S_CREAD, S_CEMIT, S_FIN, S_DRAIN, S_FLUSH
   } state_type;

   typedef enum logic [1:0] {T_R1, T_R2, T_L1, T_L2} test_type;

   portal_type pm_mem [MAX_PORTALS];
   wp_type     wp_mem [MAX_WAYPOINTS];

   state_type  state_ff;
   test_type   test_ff;
   point_type  start_ff, target_ff;
   logic [6:0] max_wp_ff;
   logic [6:0] count_ff, idx_ff, left_id_ff, right_id_ff, corner_ff, n_ff, k_ff;
   logic [GD_W-1:0] guard_ff;
   point_type  apex_ff, left_ff, right_ff, nl_ff, nr_ff, prev_ff;
   logic       at_tgt_ff, use_left_ff, budget_ff;
   portal_type pm_rd_ff;
   wp_type     wp_rd_ff;
   logic       rdv_ff, rdlast_ff;
   logic signed [65:0] prod_ff, acc_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;

   logic [6:0] lim;
   logic [PA_W-1:0] pm_raddr;
   point_type  b_pt, c_pt, corner_pt;
   logic signed [32:0] m_a, m_b;
   logic signed [65:0] mul_out;
   logic signed [66:0] area;
   logic [16:0] corner_vtx;

   always_comb begin
      if (max_wp_ff < 7'd2) lim = 7'd2;
      else if (max_wp_ff > 7'(MAX_WAYPOINTS)) lim = 7'(MAX_WAYPOINTS);
      else lim = max_wp_ff;
      pm_raddr = (state_ff == S_CREAD) ? corner_ff[PA_W-1:0] : idx_ff[PA_W-1:0];
      b_pt = (test_ff == T_R1 || test_ff == T_L2) ? right_ff : left_ff;
      c_pt = (test_ff == T_R1 || test_ff == T_R2) ? nr_ff : nl_ff;
      if (state_ff == S_AR1) begin
         m_a = 33'(b_pt.x) - 33'(apex_ff.x);
         m_b = 33'(c_pt.z) - 33'(apex_ff.z);
      end else begin
         m_a = 33'(b_pt.z) - 33'(apex_ff.z);
         m_b = 33'(c_pt.x) - 33'(apex_ff.x);
      end
      mul_out = m_a * m_b;
      area = 67'(acc_ff) - 67'(prod_ff);
      corner_pt = use_left_ff ? left_ff : right_ff;
      if (corner_ff < count_ff)
         corner_vtx = use_left_ff ? 17'(pm_rd_ff.lv) : 17'(pm_rd_ff.rv);
      else
         corner_vtx = NO_VERTEX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         test_ff      <= T_R1;
         start_ff     <= '0;
         target_ff    <= '0;
         max_wp_ff    <= 7'd64;
         count_ff     <= '0;
         idx_ff       <= '0;
         left_id_ff   <= NO_PORTAL;
         right_id_ff  <= NO_PORTAL;
         corner_ff    <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         guard_ff     <= '0;
         apex_ff      <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         prev_ff      <= '0;
         at_tgt_ff    <= 1'b0;
         use_left_ff  <= 1'b0;
         budget_ff    <= 1'b0;
         rdv_ff       <= 1'b0;
         rdlast_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pm_rd_ff     <= pm_mem[pm_raddr];
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         if (rdv_ff) begin
            rsp_valid_ff           <= 1'b1;
            rsp_ff.pos_x           <= wp_rd_ff.p.x;
            rsp_ff.pos_y           <= wp_rd_ff.p.y;
            rsp_ff.pos_z           <= wp_rd_ff.p.z;
            rsp_ff.kind            <= wp_rd_ff.kind;
            rsp_ff.portal_index    <= wp_rd_ff.portal;
            rsp_ff.vertex_index    <= wp_rd_ff.vertex;
            rsp_ff.budget_exceeded <= budget_ff;
            rsp_ff.last            <= rdlast_ff;
            rsp_ff.load_overflow   <= 1'b0;
         end

         if (csr_we) begin
            unique case (csr_index)
               CSR_START_X:  start_ff.x  <= csr_wdata;
               CSR_START_Y:  start_ff.y  <= csr_wdata;
               CSR_START_Z:  start_ff.z  <= csr_wdata;
               CSR_TARGET_X: target_ff.x <= csr_wdata;
               CSR_TARGET_Y: target_ff.y <= csr_wdata;
               CSR_TARGET_Z: target_ff.z <= csr_wdata;
               CSR_MAX_WP:   max_wp_ff   <= csr_wdata[6:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (start && !req.func) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{pos_x: '0, pos_y: '0, pos_z: '0, kind: '0,
                                    portal_index: NO_PORTAL, vertex_index: NO_VERTEX,
                                    budget_exceeded: 1'b0, last: 1'b0,
                                    load_overflow: (count_ff >= 7'(MAX_PORTALS))};
                  if (count_ff < 7'(MAX_PORTALS)) begin
                     pm_mem[count_ff[PA_W-1:0]] <= '{
                        l: '{req.left_x, req.left_y, req.left_z},
                        r: '{req.right_x, req.right_y, req.right_z},
                        lv: req.left_vertex, rv: req.right_vertex};
                     count_ff <= count_ff + 7'd1;
                  end
               end else if (start) begin
                  wp_mem[0]   <= '{p: start_ff, kind: KIND_START, portal: NO_PORTAL,
                                   vertex: NO_VERTEX};
                  n_ff        <= 7'd1;
                  prev_ff     <= start_ff;
                  apex_ff     <= start_ff;
                  left_ff     <= start_ff;
                  right_ff    <= start_ff;
                  left_id_ff  <= NO_PORTAL;
                  right_id_ff <= NO_PORTAL;
                  idx_ff      <= '0;
                  guard_ff    <= '0;
                  budget_ff   <= 1'b0;
                  state_ff    <= S_STEP;
               end
            end
            S_STEP: begin
               if (idx_ff > count_ff) begin
                  state_ff <= S_FIN;
               end else if (guard_ff == GD_W'(ITER_LIMIT)) begin
                  budget_ff <= 1'b1;
                  state_ff  <= S_FIN;
               end else begin
                  guard_ff  <= guard_ff + GD_W'(1);
                  at_tgt_ff <= (idx_ff == count_ff);
                  test_ff   <= T_R1;
                  if (idx_ff == count_ff) begin
                     nl_ff    <= target_ff;
                     nr_ff    <= target_ff;
                     state_ff <= S_AR1;
                  end else begin
                     state_ff <= S_LOAD;
                  end
               end
            end
            S_LOAD: begin
               nl_ff    <= pm_rd_ff.l;
               nr_ff    <= pm_rd_ff.r;
               state_ff <= S_AR1;
            end
            S_AR1: begin
               prod_ff  <= mul_out;
               state_ff <= S_AR2;
            end
            S_AR2: begin
               acc_ff   <= prod_ff;
               prod_ff  <= mul_out;
               state_ff <= S_AR3;
            end
            S_AR3: begin
               state_ff <= S_AR1;
               case (test_ff)
                  T_R1: begin
                     if (area <= EPS) begin
                        if (apex_ff == right_ff) begin
                           right_ff    <= nr_ff;
                           right_id_ff <= at_tgt_ff ? NO_PORTAL : idx_ff;
                           test_ff     <= T_L1;
                        end else begin
                           test_ff <= T_R2;
                        end
                     end else begin
                        test_ff <= T_L1;
                     end
                  end
                  T_R2: begin
                     if (area > EPS) begin
                        right_ff    <= nr_ff;
                        right_id_ff <= at_tgt_ff ? NO_PORTAL : idx_ff;
                        test_ff     <= T_L1;
                     end else begin
                        corner_ff   <= (left_id_ff == NO_PORTAL) ? idx_ff : left_id_ff;
                        use_left_ff <= 1'b1;
                        state_ff    <= S_CREAD;
                     end
                  end
                  T_L1: begin
                     if (area >= -EPS) begin
                        if (apex_ff == left_ff) begin
                           left_ff    <= nl_ff;
                           left_id_ff <= at_tgt_ff ? NO_PORTAL : idx_ff;
                           idx_ff     <= idx_ff + 7'd1;
                           state_ff   <= S_STEP;
                        end else begin
                           test_ff <= T_L2;
                        end
                     end else begin
                        idx_ff   <= idx_ff + 7'd1;
                        state_ff <= S_STEP;
                     end
                  end
                  default: begin
                     if (area < -EPS) begin
                        left_ff    <= nl_ff;
                        left_id_ff <= at_tgt_ff ? NO_PORTAL : idx_ff;
                        idx_ff     <= idx_ff + 7'd1;
                        state_ff   <= S_STEP;
                     end else begin
                        corner_ff   <= (right_id_ff == NO_PORTAL) ? idx_ff : right_id_ff;
                        use_left_ff <= 1'b0;
                        state_ff    <= S_CREAD;
                     end
                  end
               endcase
            end
            S_CREAD: begin
               state_ff <= S_CEMIT;
            end
            S_CEMIT: begin
               if (prev_ff != corner_pt && n_ff >= lim) begin
                  budget_ff <= 1'b1;
                  state_ff  <= S_FIN;
               end else begin
                  if (prev_ff != corner_pt) begin
                     wp_mem[n_ff[WA_W-1:0]] <= '{p: corner_pt, kind: KIND_CORNER,
                                                 portal: corner_ff, vertex: corner_vtx};
                     n_ff    <= n_ff + 7'd1;
                     prev_ff <= corner_pt;
                  end
                  apex_ff     <= corner_pt;
                  left_ff     <= corner_pt;
                  right_ff    <= corner_pt;
                  left_id_ff  <= corner_ff;
                  right_id_ff <= corner_ff;
                  idx_ff      <= corner_ff + 7'd1;
                  state_ff    <= S_STEP;
               end
            end
            S_FIN: begin
               if (!budget_ff && prev_ff != target_ff) begin
                  if (n_ff >= lim) begin
                     budget_ff <= 1'b1;
                  end else begin
                     wp_mem[n_ff[WA_W-1:0]] <= '{p: target_ff, kind: KIND_TARGET,
                                                 portal: NO_PORTAL, vertex: NO_VERTEX};
                     n_ff <= n_ff + 7'd1;
                  end
               end
               count_ff <= '0;
               k_ff     <= '0;
               state_ff <= S_DRAIN;
            end
            S_DRAIN: begin
               wp_rd_ff  <= wp_mem[k_ff[WA_W-1:0]];
               rdv_ff    <= 1'b1;
               rdlast_ff <= (k_ff == n_ff - 7'd1);
               k_ff      <= k_ff + 7'd1;
               if (k_ff == n_ff - 7'd1) state_ff <= S_FLUSH;
            end
            S_FLUSH: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
endmodule
`default_nettype wire
